FILE: hw/rtl/nns_pkg.sv
// nns_pkg: shared sizes, payload structs, queue command and back-end states
// for the nearest-neighbor rgb scaler; depends on nothing
package nns_pkg;

    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int MAX_DST_SIDE   = 4096;

    // register field widths
    localparam int SRC_W = 9;
    localparam int DST_W = 13;
    localparam int CFG_W = 13;

    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LP_W        = $clog2(STORE_DEPTH + 1);
    localparam int POS_W       = $clog2(MAX_DST_SIDE);
    localparam int MAX_SRC_SIDE =
        (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
    localparam int QUOT_W      = $clog2(MAX_SRC_SIDE + 1);
    localparam int NUM_W       = POS_W + SRC_W + 1;
    localparam int DEN_W       = DST_W + 1;
    localparam int STEP_W      = $clog2(QUOT_W);
    localparam int QDEPTH      = 4;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t REG_SRC_WIDTH  = 2'd0;
    localparam cfg_idx_t REG_SRC_HEIGHT = 2'd1;
    localparam cfg_idx_t REG_DST_WIDTH  = 2'd2;
    localparam cfg_idx_t REG_DST_HEIGHT = 2'd3;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_pixel;
        logic       out_of_range;
    } out_t;

    // clamped image sizes
    typedef struct packed {
        logic [SRC_W-1:0] sw;
        logic [SRC_W-1:0] sh;
        logic [DST_W-1:0] dw;
        logic [DST_W-1:0] dh;
    } sizes_t;

    // ptr: store address for a load, loaded pixel count for a request
    typedef struct packed {
        logic             is_req;
        logic [23:0]      pix;
        logic [LP_W-1:0]  ptr;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_ADDR,
        BK_READ,
        BK_RESP
    } bk_state_t;

    function automatic logic [SRC_W-1:0] clamp_src(input logic [SRC_W-1:0] v,
                                                   input logic [SRC_W-1:0] maxv);
        logic [SRC_W-1:0] r;
        if (v == '0)
            r = SRC_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [DST_W-1:0] clamp_dst(input logic [DST_W-1:0] v);
        logic [DST_W-1:0] r;
        if (v == '0)
            r = DST_W'(1);
        else if (v > DST_W'(MAX_DST_SIDE))
            r = DST_W'(MAX_DST_SIDE);
        else
            r = v;
        return r;
    endfunction

endpackage

FILE: hw/rtl/nns_front.sv
// nns_front: accepts input words, tracks load pointer and destination
// position, and turns each word into a queue command; uses nns_pkg
module nns_front
    import nns_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  sizes_t sizes,
    input  logic   in_valid,
    output logic   in_ready,
    input  in_t    in_data,
    input  logic   q_full,
    output logic   q_push,
    output cmd_t   q_data
);

    logic [LP_W-1:0]  lp_reg, lp_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] col_reg, col_next;

    logic [LP_W-1:0]  frame;
    logic [LP_W-1:0]  wr_ptr;
    logic [POS_W-1:0] row_cur, col_cur;
    logic [DST_W-1:0] row_inc, col_inc;
    logic             pos_out;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    assign frame  = LP_W'(sizes.sw) * LP_W'(sizes.sh);
    // a full frame restarts at address zero
    assign wr_ptr = (lp_reg >= frame) ? '0 : lp_reg;

    // position left past the image by a size change restarts at the origin
    assign pos_out = (DST_W'(row_reg) >= sizes.dh) || (DST_W'(col_reg) >= sizes.dw);
    assign row_cur = pos_out ? '0 : row_reg;
    assign col_cur = pos_out ? '0 : col_reg;
    assign row_inc = DST_W'(row_cur) + DST_W'(1);
    assign col_inc = DST_W'(col_cur) + DST_W'(1);

    always_comb
    begin
        lp_next  = lp_reg;
        row_next = row_reg;
        col_next = col_reg;
        q_data.is_req = in_data.mode;
        q_data.pix    = {in_data.red_in, in_data.green_in, in_data.blue_in};
        q_data.row    = row_cur;
        q_data.col    = col_cur;
        q_data.last   = (row_inc == sizes.dh) && (col_inc == sizes.dw);
        q_data.ptr    = lp_reg;
        if (in_data.mode == MODE_LOAD)
        begin
            q_data.ptr = wr_ptr;
            if (q_push)
                lp_next = wr_ptr + LP_W'(1);
        end
        else if (q_push)
        begin
            if (col_inc >= sizes.dw)
            begin
                col_next = '0;
                row_next = (row_inc >= sizes.dh) ? '0 : row_inc[POS_W-1:0];
            end
            else
            begin
                col_next = col_inc[POS_W-1:0];
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg  <= '0;
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            lp_reg  <= lp_next;
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

FILE: hw/rtl/nns_cmdq.sv
// nns_cmdq: short command queue between front and back end
// uses nns_pkg for the command type and depth
module nns_cmdq
    import nns_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t head
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    cmd_t             slot_reg [QDEPTH];
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(QDEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = slot_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + PTR_W'(1) : wp_reg;
        rp_next  = pop ? rp_reg + PTR_W'(1) : rp_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= push_data;
    end

endmodule

FILE: hw/rtl/nns_div.sv
// nns_div: restoring divider, one quotient bit per cycle, msb first
// uses nns_pkg for widths
module nns_div
    import nns_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              busy,
    output logic [QUOT_W-1:0] quot
);

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [NUM_W-1:0]  trial;
    logic              fits;

    assign trial = NUM_W'(den_reg) << step_reg;
    assign fits  = (rem_reg >= trial);
    assign busy  = busy_reg;
    assign quot  = quot_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = num;
            quot_next = '0;
            step_next = STEP_W'(QUOT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? rem_reg - trial : rem_reg;
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            busy_next = (step_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (start)
            den_reg <= den;
    end

endmodule

FILE: hw/rtl/nns_back.sv
// nns_back: executes queued commands: frame store writes, source index
// division, address compute, store read and result register; uses nns_pkg, nns_div
module nns_back
    import nns_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  sizes_t sizes,
    input  logic   q_valid,
    input  cmd_t   q_head,
    output logic   q_pop,
    output logic   out_valid,
    input  logic   out_ready,
    output out_t   out_data
);

    bk_state_t state_reg, state_next;

    logic [23:0]       mem [STORE_DEPTH];
    logic [23:0]       rd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              bad_reg;
    logic [LP_W-1:0]   lp_reg;
    logic              last_reg;
    logic              out_valid_reg;
    out_t              out_reg;

    logic              div_start, mem_we, addr_ld, mem_re, out_ld;
    logic [NUM_W-1:0]  num_r, num_c;
    logic              busy_r, busy_c;
    logic [QUOT_W-1:0] quot_r, quot_c;
    logic [SRC_W-1:0]  src_r, src_c;
    logic [LP_W-1:0]   addr_full;

    assign num_r = ((NUM_W'(q_head.row) * NUM_W'(sizes.sh)) << 1) + NUM_W'(sizes.dh);
    assign num_c = ((NUM_W'(q_head.col) * NUM_W'(sizes.sw)) << 1) + NUM_W'(sizes.dw);

    nns_div u_div_row (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_r),
        .den   ({sizes.dh, 1'b0}),
        .busy  (busy_r),
        .quot  (quot_r)
    );

    nns_div u_div_col (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_c),
        .den   ({sizes.dw, 1'b0}),
        .busy  (busy_c),
        .quot  (quot_c)
    );

    // rounding up to the source size falls back to the last row or column
    assign src_r = (SRC_W'(quot_r) >= sizes.sh) ? sizes.sh - SRC_W'(1) : SRC_W'(quot_r);
    assign src_c = (SRC_W'(quot_c) >= sizes.sw) ? sizes.sw - SRC_W'(1) : SRC_W'(quot_c);
    assign addr_full = LP_W'(src_r) * LP_W'(sizes.sw) + LP_W'(src_c);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        mem_we     = 1'b0;
        addr_ld    = 1'b0;
        mem_re     = 1'b0;
        out_ld     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_head.is_req)
                    begin
                        div_start  = 1'b1;
                        state_next = BK_DIV;
                    end
                    else
                        mem_we = 1'b1;
                end
            end
            BK_DIV:
            begin
                if (!busy_r && !busy_c)
                    state_next = BK_ADDR;
            end
            BK_ADDR:
            begin
                addr_ld    = 1'b1;
                state_next = BK_READ;
            end
            BK_READ:
            begin
                mem_re     = 1'b1;
                state_next = BK_RESP;
            end
            BK_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_ld     = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_ld)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[q_head.ptr[ADDR_W-1:0]] <= q_head.pix;
        if (mem_re)
            rd_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            lp_reg   <= q_head.ptr;
            last_reg <= q_head.last;
        end
        if (addr_ld)
        begin
            addr_reg <= addr_full[ADDR_W-1:0];
            bad_reg  <= (addr_full >= lp_reg);
        end
        if (out_ld)
        begin
            out_reg.red_out      <= bad_reg ? 8'd0 : rd_reg[23:16];
            out_reg.green_out    <= bad_reg ? 8'd0 : rd_reg[15:8];
            out_reg.blue_out     <= bad_reg ? 8'd0 : rd_reg[7:0];
            out_reg.last_pixel   <= last_reg;
            out_reg.out_of_range <= bad_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: hw/rtl/nearest_neighbor_rgb_scaler.sv
// nearest_neighbor_rgb_scaler: top level, size registers, front end, command
// queue and back end; uses nns_pkg, nns_front, nns_cmdq, nns_back
//
//  channel  signals                                   payload
//  in       in_valid / in_ready / in_data             in_t: mode, rgb of a load
//  out      out_valid / out_ready / out_data          out_t: rgb, last, range flag
//  cfg      cfg_valid / cfg_ready / cfg_index, data   size register write
//
// the front takes one word a cycle while the command queue has room
// a load is popped and written through the frame store write port in the same cycle
// a request goes through the pop, the two 9-step dividers
// that find the source row and column, then address, store read, result
// a full result register holds the back end; the queue then fills and stalls in
// reset clears counters, queue and state; the frame store is not cleared
module nearest_neighbor_rgb_scaler
    import nns_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_t             out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  cfg_idx_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [SRC_W-1:0] src_width_reg, src_height_reg;
    logic [DST_W-1:0] dst_width_reg, dst_height_reg;
    sizes_t           sizes;

    logic q_full, q_push, q_pop, q_valid;
    cmd_t q_data, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_W'(256);
            src_height_reg <= SRC_W'(256);
            dst_width_reg  <= DST_W'(256);
            dst_height_reg <= DST_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data[DST_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= cfg_data[DST_W-1:0];
                default:        src_width_reg  <= src_width_reg;
            endcase
        end
    end

    assign sizes.sw = clamp_src(src_width_reg, SRC_W'(MAX_SRC_WIDTH));
    assign sizes.sh = clamp_src(src_height_reg, SRC_W'(MAX_SRC_HEIGHT));
    assign sizes.dw = clamp_dst(dst_width_reg);
    assign sizes.dh = clamp_dst(dst_height_reg);

    nns_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .sizes    (sizes),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    nns_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    nns_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .sizes     (sizes),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // a pixel flagged out of range is always black
    a_oor_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_of_range |->
            out_data.red_out == 8'd0 && out_data.green_out == 8'd0 &&
            out_data.blue_out == 8'd0)
        else $error("out of range pixel not black");

    a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> q_valid && !in_ready)
        else $error("queue full flag inconsistent");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_sizes_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        sizes.sw != '0 && sizes.sh != '0 && sizes.dw != '0 && sizes.dh != '0)
        else $error("clamped size is zero");

endmodule

FILE: tb/sv/nearest_neighbor_rgb_scaler_tb.sv
// nearest_neighbor_rgb_scaler_tb: self-checking bench for the rgb scaler, a directed
// table then random frames of loads and pixel requests, checked against a scaler model
// depends on nns_pkg and nearest_neighbor_rgb_scaler
module nearest_neighbor_rgb_scaler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nns_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int LATE_ITEMS   = 120;
    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_DIRECTED = 36;

    typedef enum logic [1:0] {
        ROW_SIZE,
        ROW_WORD,
        ROW_FIXED
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        cfg_idx_t         idx;
        logic [CFG_W-1:0] val;
        in_t              word;
        out_t             want;
    } stim_row_t;

    localparam in_t  NO_WORD   = '0;
    localparam out_t NO_RESULT = '0;

    localparam cfg_idx_t SIZE_REGS [4] =
        '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT};

    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // nothing loaded yet
        '{ROW_FIXED, REG_SRC_WIDTH, 13'h0000, '{MODE_REQUEST, 8'h5A, 8'hC3, 8'h0F},
          '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        // zero sizes act as 1, bits above the 9-bit source fields are dropped
        '{ROW_SIZE, REG_SRC_WIDTH,  13'h0000, NO_WORD, NO_RESULT},
        '{ROW_SIZE, REG_SRC_HEIGHT, 13'h1E01, NO_WORD, NO_RESULT},
        '{ROW_SIZE, REG_DST_WIDTH,  13'h0000, NO_WORD, NO_RESULT},
        '{ROW_SIZE, REG_DST_HEIGHT, 13'h0001, NO_WORD, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_LOAD, 8'hFF, 8'h00, 8'hA5}, NO_RESULT},
        '{ROW_FIXED, REG_SRC_WIDTH, 13'h0000, '{MODE_REQUEST, 8'h00, 8'h00, 8'h00},
          '{8'hFF, 8'h00, 8'hA5, 1'b1, 1'b0}},
        // frame full, the next load starts over at address 0
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_LOAD, 8'h00, 8'hFF, 8'h5A}, NO_RESULT},
        '{ROW_FIXED, REG_SRC_WIDTH, 13'h0000, '{MODE_REQUEST, 8'hFF, 8'hFF, 8'hFF},
          '{8'h00, 8'hFF, 8'h5A, 1'b1, 1'b0}},
        '{ROW_FIXED, REG_SRC_WIDTH, 13'h0000, '{MODE_REQUEST, 8'h00, 8'h00, 8'h00},
          '{8'h00, 8'hFF, 8'h5A, 1'b1, 1'b0}},
        // largest sizes, oversize values clamp
        '{ROW_SIZE, REG_SRC_WIDTH,  13'h01FF, NO_WORD, NO_RESULT},
        '{ROW_SIZE, REG_SRC_HEIGHT, 13'h0100, NO_WORD, NO_RESULT},
        '{ROW_SIZE, REG_DST_WIDTH,  13'h1FFF, NO_WORD, NO_RESULT},
        '{ROW_SIZE, REG_DST_HEIGHT, 13'h1000, NO_WORD, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_LOAD, 8'hFF, 8'hFF, 8'hFF}, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_LOAD, 8'h00, 8'h00, 8'h00}, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_REQUEST, 8'hFF, 8'h00, 8'hFF}, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_REQUEST, 8'h00, 8'hFF, 8'h00}, NO_RESULT},
        // 1x2 up to 2x2: the rounded column reaches the width and falls back to floor
        '{ROW_SIZE, REG_SRC_WIDTH,  13'h0001, NO_WORD, NO_RESULT},
        '{ROW_SIZE, REG_SRC_HEIGHT, 13'h0002, NO_WORD, NO_RESULT},
        '{ROW_SIZE, REG_DST_WIDTH,  13'h0002, NO_WORD, NO_RESULT},
        '{ROW_SIZE, REG_DST_HEIGHT, 13'h0002, NO_WORD, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_LOAD, 8'h12, 8'h34, 8'h56}, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_LOAD, 8'hAB, 8'hCD, 8'hEF}, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_REQUEST, 8'h00, 8'h00, 8'h00}, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_REQUEST, 8'h00, 8'h00, 8'h00}, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_REQUEST, 8'h00, 8'h00, 8'h00}, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_REQUEST, 8'h00, 8'h00, 8'h00}, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_REQUEST, 8'h00, 8'h00, 8'h00}, NO_RESULT},
        // 4x4 with only two pixels loaded
        '{ROW_SIZE, REG_SRC_WIDTH,  13'h0004, NO_WORD, NO_RESULT},
        '{ROW_SIZE, REG_SRC_HEIGHT, 13'h0004, NO_WORD, NO_RESULT},
        '{ROW_SIZE, REG_DST_WIDTH,  13'h0004, NO_WORD, NO_RESULT},
        '{ROW_SIZE, REG_DST_HEIGHT, 13'h0004, NO_WORD, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_REQUEST, 8'h00, 8'h00, 8'h00}, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_REQUEST, 8'h00, 8'h00, 8'h00}, NO_RESULT},
        '{ROW_WORD, REG_SRC_WIDTH, 13'h0000, '{MODE_REQUEST, 8'h00, 8'h00, 8'h00}, NO_RESULT}
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_t              in_data;
    logic             out_valid;
    logic             out_ready;
    out_t             out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // scaler model state
    logic [23:0]  pixel_store [STORE_DEPTH];
    int unsigned  load_count;
    int unsigned  dest_row;
    int unsigned  dest_col;
    logic [CFG_W-1:0] size_src_w;
    logic [CFG_W-1:0] size_src_h;
    logic [CFG_W-1:0] size_dst_w;
    logic [CFG_W-1:0] size_dst_h;

    out_t expected_pixels [$];
    int   mismatches;
    bit   quiet;
    bit   hold_request;

    nearest_neighbor_rgb_scaler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned clamp_size(int unsigned raw, int unsigned maxv);
        if (raw == 0)
            return 1;
        return (raw > maxv) ? maxv : raw;
    endfunction

    // destination index k on a side of n pixels to the nearest of m source pixels
    function automatic int unsigned nearest_src(int unsigned k, int unsigned m,
                                                int unsigned n);
        longint unsigned num;
        longint unsigned r;
        num = 64'd2 * k * m + n;
        r = num / (64'd2 * n);
        if (r >= m)
            r = (64'd1 * k * m) / n;
        return int'(r);
    endfunction

    function automatic void apply_size_write(cfg_idx_t idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_SRC_WIDTH:  size_src_w = {4'b0, val[SRC_W-1:0]};
            REG_SRC_HEIGHT: size_src_h = {4'b0, val[SRC_W-1:0]};
            REG_DST_WIDTH:  size_dst_w = val;
            REG_DST_HEIGHT: size_dst_h = val;
            default: ;
        endcase
    endfunction

    // returns 1 with the expected pixel for a request, 0 for a load
    function automatic bit advance_scaler(in_t w, output out_t px);
        int unsigned sw;
        int unsigned sh;
        int unsigned dw;
        int unsigned dh;
        int unsigned addr;
        bit          bad;
        sw = clamp_size(size_src_w, MAX_SRC_WIDTH);
        sh = clamp_size(size_src_h, MAX_SRC_HEIGHT);
        dw = clamp_size(size_dst_w, MAX_DST_SIDE);
        dh = clamp_size(size_dst_h, MAX_DST_SIDE);
        px = '0;
        if (w.mode == MODE_LOAD)
        begin
            if (load_count >= sw * sh)
                load_count = 0;
            pixel_store[load_count] = {w.red_in, w.green_in, w.blue_in};
            load_count++;
            return 1'b0;
        end
        if (dest_row >= dh || dest_col >= dw)
        begin
            dest_row = 0;
            dest_col = 0;
        end
        addr = nearest_src(dest_row, sh, dh) * sw + nearest_src(dest_col, sw, dw);
        bad = (addr >= load_count);
        if (!bad)
        begin
            px.red_out   = pixel_store[addr][23:16];
            px.green_out = pixel_store[addr][15:8];
            px.blue_out  = pixel_store[addr][7:0];
        end
        px.last_pixel   = (dest_row == dh - 1) && (dest_col == dw - 1);
        px.out_of_range = bad;
        if (dest_col + 1 >= dw)
        begin
            dest_col = 0;
            dest_row = (dest_row + 1 >= dh) ? 0 : dest_row + 1;
        end
        else
        begin
            dest_col++;
        end
        return 1'b1;
    endfunction

    // valid stays high when words follow back to back; it only drops for a gap
    task automatic send_word(in_t w, bit fixed_en, out_t fixed_px);
        out_t px;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        if (advance_scaler(w, px))
            expected_pixels.push_back(fixed_en ? fixed_px : px);
    endtask

    // caller lowers cfg_valid after the last write of a group
    task automatic write_size(cfg_idx_t idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_size_write(idx, val);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin : result_check
        out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t ns: unexpected word, expected none, actual %p",
                             $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("red_out", want.red_out, out_data.red_out);
                    check_field("green_out", want.green_out, out_data.green_out);
                    check_field("blue_out", want.blue_out, out_data.blue_out);
                    check_field("last_pixel", want.last_pixel, out_data.last_pixel);
                    check_field("out_of_range", want.out_of_range, out_data.out_of_range);
                end
            end
        end
    end

    initial
    begin : result_ready
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(1, 5) - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned      items_sent;
        int unsigned      frame;
        int unsigned      pixels;
        int unsigned      n_load;
        int unsigned      n_req;
        bit               cfg_open;
        bit               raw_sizes;
        bit               phase_quiet;
        bit               hold_done;
        logic [CFG_W-1:0] val;
        in_t              w;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_SRC_WIDTH;
        cfg_data   <= '0;
        mismatches = 0;
        quiet      = 1'b0;
        hold_request = 1'b0;
        hold_done  = 1'b0;
        cfg_open   = 1'b0;
        items_sent = 0;
        load_count = 0;
        dest_row   = 0;
        dest_col   = 0;
        size_src_w = 13'd256;
        size_src_h = 13'd256;
        size_dst_w = 13'd256;
        size_dst_h = 13'd256;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].kind == ROW_SIZE)
            begin
                if (!cfg_open)
                    wait_drained();
                write_size(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].val);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                    cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                send_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].kind == ROW_FIXED,
                          DIRECTED_ROWS[i].want);
            end
        end

        // random frames: mostly a full source frame then a full destination image
        while (items_sent < RANDOM_ITEMS)
        begin
            wait_drained();
            raw_sizes   = ($urandom_range(0, 5) == 0);
            phase_quiet = ($urandom_range(0, 3) == 0);
            foreach (SIZE_REGS[i])
            begin
                if (raw_sizes)
                    val = CFG_W'($urandom_range(0, 8191));
                else if (i < 2)
                    val = CFG_W'($urandom_range(1, 6));
                else
                    val = CFG_W'($urandom_range(1, 10));
                write_size(SIZE_REGS[i], val);
            end
            cfg_valid <= 1'b0;

            frame  = clamp_size(size_src_w, MAX_SRC_WIDTH) *
                     clamp_size(size_src_h, MAX_SRC_HEIGHT);
            pixels = clamp_size(size_dst_w, MAX_DST_SIDE) *
                     clamp_size(size_dst_h, MAX_DST_SIDE);
            n_load = (frame <= 36) ? frame : $urandom_range(0, 48);
            if ($urandom_range(0, 3) == 0)
                n_load = $urandom_range(0, n_load + 3);
            n_req = (pixels <= 100) ? pixels : $urandom_range(1, 80);
            if ($urandom_range(0, 3) == 0)
                n_req += $urandom_range(0, 6);

            // results back up behind a long receiver stall while words keep coming
            if (!hold_done && (n_req >= 8 || items_sent > RANDOM_ITEMS / 2))
            begin
                hold_request = 1'b1;
                hold_done = 1'b1;
            end

            for (int k = 0; k < n_load + n_req; k++)
            begin
                quiet = phase_quiet || (items_sent >= RANDOM_ITEMS - LATE_ITEMS);
                w.mode      = (k < n_load) ? MODE_LOAD : MODE_REQUEST;
                w.red_in    = 8'($urandom);
                w.green_in  = 8'($urandom);
                w.blue_in   = 8'($urandom);
                if ($urandom_range(0, 11) == 0)
                    w.mode = 1'($urandom);
                send_word(w, 1'b0, NO_RESULT);
                items_sent++;
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/nns_pkg.sv
hw/rtl/nns_front.sv
hw/rtl/nns_cmdq.sv
hw/rtl/nns_div.sv
hw/rtl/nns_back.sv
hw/rtl/nearest_neighbor_rgb_scaler.sv
tb/sv/nearest_neighbor_rgb_scaler_tb.sv
